// File: src/afrs_pkg.sv
// shared types and constants of the arm64 function reference scanner
package afrs_pkg;

    localparam logic [31:0] INSN_RET   = 32'hD65F03C0;
    localparam logic [31:0] ADRP_MASK  = 32'h9F000000;
    localparam logic [31:0] ADRP_CODE  = 32'h90000000;
    localparam logic [31:0] ADDI_MASK  = 32'hFFC00000;
    localparam logic [31:0] ADDI_CODE  = 32'h91000000;
    localparam logic [31:0] STP_MASK   = 32'hFFC07FFF;
    localparam logic [31:0] STP_CODE   = 32'hA9807BFD;
    localparam logic [31:0] SUBSP_MASK = 32'hFFC003FF;
    localparam logic [31:0] SUBSP_CODE = 32'hD10003FF;
    localparam logic [63:0] PAGE_LOW   = 64'h0000_0000_0000_0FFF;

    localparam logic [1:0] MODE_SEEK  = 2'd0;
    localparam logic [1:0] MODE_INFN  = 2'd1;
    localparam logic [1:0] MODE_FOUND = 2'd2;

    localparam logic CFG_SECTION_BASE   = 1'b0;
    localparam logic CFG_TARGET_ADDRESS = 1'b1;

    typedef struct packed {
        logic [1:0]  scan_mode;
        logic [63:0] word_address;
        logic [63:0] function_start;
        logic        pending_valid;
        logic [4:0]  pending_register;
        logic [63:0] pending_page_value;
        logic        result_given;
    } scan_state_t;

    typedef struct packed {
        logic        emit;
        logic        found;
        logic [63:0] function_address;
    } step_result_t;

endpackage

// File: src/afrs_if.sv
// channel interfaces: instruction words, results and configuration writes
interface afrs_insn_if;
    logic        valid;
    logic        ready;
    logic [31:0] insn_word;
    logic        last_word;

    modport source (output valid, output insn_word, output last_word, input ready);
    modport sink (input valid, input insn_word, input last_word, output ready);
endinterface

interface afrs_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] function_address;

    modport source (output valid, output found, output function_address, input ready);
    modport sink (input valid, input found, input function_address, output ready);
endinterface

interface afrs_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/afrs_step.sv
// scan step: decodes one instruction word and computes the next scan state
module afrs_step
    import afrs_pkg::*;
(
    input  scan_state_t  state,
    input  logic [31:0]  insn_word,
    input  logic         last_word,
    input  logic [63:0]  section_base,
    input  logic [63:0]  target_address,
    output scan_state_t  state_next,
    output step_result_t result
);

    logic        is_addi;
    logic        is_adrp;
    logic        is_prologue;
    logic        is_ret;
    logic        pair_hit;
    logic [63:0] resolved;
    logic [20:0] adrp_imm;
    logic [63:0] adrp_page;
    logic        ret_report;
    scan_state_t work;

    assign is_addi     = (insn_word & ADDI_MASK) == ADDI_CODE;
    assign is_adrp     = (insn_word & ADRP_MASK) == ADRP_CODE;
    assign is_ret      = insn_word == INSN_RET;
    assign is_prologue = ((insn_word & STP_MASK) == STP_CODE)
                      || ((insn_word & SUBSP_MASK) == SUBSP_CODE);

    assign pair_hit = state.pending_valid && is_addi
                   && (insn_word[4:0] == state.pending_register)
                   && (insn_word[9:5] == state.pending_register);
    assign resolved = state.pending_page_value + {52'd0, insn_word[21:10]};

    // immhi:immlo, sign extended and scaled to a page
    assign adrp_imm  = {insn_word[23:5], insn_word[30:29]};
    assign adrp_page = (state.word_address & ~PAGE_LOW)
                     + {{31{adrp_imm[20]}}, adrp_imm, 12'd0};

    assign ret_report = !state.result_given && !pair_hit && is_ret
                     && (state.scan_mode == MODE_FOUND);

    always_comb
    begin
        work = state;
        work.word_address = state.word_address + 64'd4;
        if (!state.result_given)
        begin
            work.pending_valid = 1'b0;
            if (pair_hit)
            begin
                if (resolved == target_address)
                begin
                    work.scan_mode = MODE_FOUND;
                end
            end
            else if (is_ret)
            begin
                if (state.scan_mode == MODE_FOUND)
                begin
                    work.result_given = 1'b1;
                end
                else
                begin
                    work.scan_mode = MODE_SEEK;
                end
            end
            else if (is_adrp)
            begin
                if (state.scan_mode == MODE_INFN && !last_word)
                begin
                    work.pending_valid      = 1'b1;
                    work.pending_register   = insn_word[4:0];
                    work.pending_page_value = adrp_page;
                end
            end
            else if (is_prologue && state.scan_mode == MODE_SEEK)
            begin
                work.function_start = state.word_address;
                work.scan_mode      = MODE_INFN;
            end
        end

        state_next = work;
        if (last_word)
        begin
            state_next = '0;
            state_next.scan_mode    = MODE_SEEK;
            state_next.word_address = section_base;
        end

        result.emit             = ret_report || (last_word && !work.result_given);
        result.found            = ret_report;
        result.function_address = ret_report ? state.function_start : 64'd0;
    end

endmodule

// File: src/arm64_function_ref_scanner.sv
// top level of the arm64 function reference scanner
// Takes one instruction word per cycle unless a result waits in a full output
// register. Each accepted word is captured in an input register, then decoded and
// applied to the scan state, and any result is held in an output register until
// transferred. The cycle time is set by the 64-bit ADRP+ADD page add and its
// compare against target_address. At most one result leaves per section: the
// referencing function's start on the RET that closes it, or a not-found result on
// the last word. Configuration writes are taken at any time and are meant for idle
// periods; writing section_base also reloads the running word address.
module arm64_function_ref_scanner
    import afrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    afrs_insn_if.sink     insn,
    afrs_result_if.source result,
    afrs_cfg_if.sink      cfg
);

    logic [63:0]  section_base_reg;
    logic [63:0]  target_address_reg;
    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_state_t  step_state;
    step_result_t step_res;

    logic        s1_valid_reg;
    logic [31:0] word_reg;
    logic        last_reg;

    logic        out_valid_reg;
    logic        found_reg;
    logic [63:0] address_reg;

    logic out_free;
    logic s1_fire;
    logic in_fire;
    logic cfg_fire;

    afrs_step u_step (
        .state          (state_reg),
        .insn_word      (word_reg),
        .last_word      (last_reg),
        .section_base   (section_base_reg),
        .target_address (target_address_reg),
        .state_next     (step_state),
        .result         (step_res)
    );

    assign out_free   = !out_valid_reg || result.ready;
    // a word that produces nothing never waits on the output register
    assign s1_fire    = s1_valid_reg && (!step_res.emit || out_free);
    assign insn.ready = !s1_valid_reg || s1_fire;
    assign in_fire    = insn.valid && insn.ready;
    assign cfg.ready  = 1'b1;
    assign cfg_fire   = cfg.valid && cfg.ready;

    assign result.valid            = out_valid_reg;
    assign result.found            = found_reg;
    assign result.function_address = address_reg;

    // a base write restarts the running address
    always_comb
    begin
        state_next = s1_fire ? step_state : state_reg;
        if (cfg_fire && cfg.index == CFG_SECTION_BASE)
        begin
            state_next.word_address = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_base_reg   <= '0;
            target_address_reg <= '0;
            state_reg          <= '0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_fire && cfg.index == CFG_SECTION_BASE)
            begin
                section_base_reg <= cfg.data;
            end
            if (cfg_fire && cfg.index == CFG_TARGET_ADDRESS)
            begin
                target_address_reg <= cfg.data;
            end

            state_reg <= state_next;

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire && step_res.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            word_reg <= insn.insn_word;
            last_reg <= insn.last_word;
        end
        if (s1_fire && step_res.emit)
        begin
            found_reg   <= step_res.found;
            address_reg <= step_res.function_address;
        end
    end

    // a held adrp only exists inside a function
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending_valid |-> state_reg.scan_mode == MODE_INFN)
        else $error("pending adrp outside a function");

    // once reported, the section stays in the found mode until it ends
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.result_given |-> state_reg.scan_mode == MODE_FOUND)
        else $error("result given without a found reference");

    // a not-found result carries a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> address_reg == 64'd0)
        else $error("not-found result with nonzero address");

    // each word inside a section advances the address by one word
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !last_reg && !(cfg_fire && cfg.index == CFG_SECTION_BASE))
        |=> state_reg.word_address == $past(state_reg.word_address) + 64'd4)
        else $error("word address did not advance");

endmodule
